/* rtl/core/middle_insert_queue_defines.svh */
// Assertion macros shared by the queue RTL.
// Each use expects signals named clock and reset in the enclosing module.
`ifndef MIDDLE_INSERT_QUEUE_DEFINES_SVH
`define MIDDLE_INSERT_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MDQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MDQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mdq_pkg.sv */
`default_nettype none

package mdq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
   localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
   localparam int NUM_W      = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;

   localparam logic [1:0] OP_PUSH_TAIL = 2'd0;
   localparam logic [1:0] OP_PUSH_MID  = 2'd1;
   localparam logic [1:0] OP_POP       = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Command to one half of the queue. rd is issued when a request is accepted,
   // ahead of the take/append/prepend that consume the registered read data.
   typedef struct packed {
      logic              rd;
      logic              take;
      logic              append;
      logic              prepend;
      logic [DATA_W-1:0] wdata;
   } ring_cmd_type;

endpackage

`default_nettype wire

/* rtl/core/mdq_intf.sv */
`default_nettype none

interface mdq_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         operation;
   logic signed [mdq_pkg::DATA_W-1:0]  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mdq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mdq_pkg::DATA_W-1:0]  popped_value;
   logic [1:0]                         status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink   (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/mdq_ring.sv */
`default_nettype none
`include "middle_insert_queue_defines.svh"

module mdq_ring (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mdq_pkg::ring_cmd_type         cmd,
   output logic [mdq_pkg::CNT_W-1:0]          count,
   output logic [mdq_pkg::DATA_W-1:0]         rdata
);

   logic [mdq_pkg::DATA_W-1:0] mem [mdq_pkg::HALF_DEPTH];
   logic [mdq_pkg::DATA_W-1:0] rdata_ff;
   logic [mdq_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [mdq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [mdq_pkg::PTR_W-1:0]  head_inc, head_dec, tail_addr, waddr;
   logic [mdq_pkg::CNT_W:0]    tail_sum, tail_wrap;
   logic                       we;

   assign count = count_ff;
   assign rdata = rdata_ff;

   assign head_inc = (head_ff == mdq_pkg::PTR_W'(mdq_pkg::HALF_DEPTH - 1)) ?
                     '0 : head_ff + mdq_pkg::PTR_W'(1);
   assign head_dec = (head_ff == '0) ?
                     mdq_pkg::PTR_W'(mdq_pkg::HALF_DEPTH - 1) : head_ff - mdq_pkg::PTR_W'(1);

   // Tail slot is head + count, wrapped once around the ring.
   assign tail_sum  = {1'b0, count_ff} + (mdq_pkg::CNT_W + 1)'(head_ff);
   assign tail_wrap = (tail_sum >= (mdq_pkg::CNT_W + 1)'(mdq_pkg::HALF_DEPTH)) ?
                      tail_sum - (mdq_pkg::CNT_W + 1)'(mdq_pkg::HALF_DEPTH) : tail_sum;
   assign tail_addr = tail_wrap[mdq_pkg::PTR_W-1:0];

   assign we    = cmd.append || cmd.prepend;
   assign waddr = cmd.prepend ? head_dec : tail_addr;

   always_comb begin
      head_in = head_ff;
      if (cmd.take) begin
         head_in = head_inc;
      end else if (cmd.prepend) begin
         head_in = head_dec;
      end
      count_in = count_ff + mdq_pkg::CNT_W'(cmd.append) + mdq_pkg::CNT_W'(cmd.prepend)
                 - mdq_pkg::CNT_W'(cmd.take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[head_ff];
      end
   end

   `MDQ_ASSERT(a_no_take_empty, !(cmd.take && count_ff == '0), "take from empty half")
   `MDQ_ASSERT(a_count_bound, count_ff <= mdq_pkg::CNT_W'(mdq_pkg::HALF_DEPTH), "half overflow")
   `MDQ_ASSERT(a_one_write, !(cmd.append && cmd.prepend), "append and prepend together")

endmodule

`default_nettype wire

/* rtl/core/middle_insert_queue.sv */
// Bounded FIFO of 32-bit values with push at tail, push at middle and pop.
// Requests arrive on req_chan (operation, value) and every request gives
// exactly one response on rsp_chan (popped_value, status), in order.
// The queue lives in two ring memories: the front half holds ceil(n/2)
// entries, the back half the rest; a middle push lands right after the
// front half, and at most one entry moves between halves per request.
// An accepted request is executed and its response registered in the
// output register. Only one request is in flight: the ring memories are
// read at acceptance and written back when the request executes.
// req_chan.ready is high whenever no request is in flight, even while the
// previous response still waits in the output register.
// If rsp_chan.ready stays low, the next request is held after its memory
// read until the output register frees up; nothing is dropped.
// Reset (synchronous, active high) empties the queue: heads and counts
// clear at once, memory contents are left as they are and never read
// before being written.
`default_nettype none
`include "middle_insert_queue_defines.svh"

module middle_insert_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   mdq_req_if.sink    req_chan,
   mdq_rsp_if.source  rsp_chan
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   typedef struct packed {
      logic       f_take;
      logic       f_append;
      logic       f_from_back;
      logic       b_take;
      logic       b_append;
      logic       b_prepend;
      logic       pop_ok;
      logic [1:0] status;
   } plan_type;

   state_type                   state_ff;
   plan_type                    plan_ff, plan_in;
   logic [mdq_pkg::DATA_W-1:0]  val_ff;
   logic                        rsp_valid_ff;
   logic [mdq_pkg::DATA_W-1:0]  rsp_popped_ff;
   logic [1:0]                  rsp_status_ff;

   mdq_pkg::ring_cmd_type       front_cmd, back_cmd;
   logic [mdq_pkg::CNT_W-1:0]   front_count, back_count;
   logic [mdq_pkg::DATA_W-1:0]  front_rdata, back_rdata;
   logic [mdq_pkg::NUM_W-1:0]   total;
   logic                        even, empty, full;
   logic                        accept, exec_fire;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign accept                = req_chan.valid && req_chan.ready;
   assign exec_fire             = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_popped_ff;
   assign rsp_chan.status       = rsp_status_ff;

   assign total = mdq_pkg::NUM_W'(front_count) + mdq_pkg::NUM_W'(back_count);
   assign even  = (front_count == back_count);
   assign empty = (total == '0);
   assign full  = (total >= mdq_pkg::NUM_W'(mdq_pkg::CAPACITY));

   // Decode the request against the current counts.
   always_comb begin
      plan_in        = '0;
      plan_in.status = mdq_pkg::STATUS_DONE;
      unique case (req_chan.operation)
         mdq_pkg::OP_PUSH_TAIL: begin
            if (full) begin
               plan_in.status = mdq_pkg::STATUS_FULL;
            end else if (empty) begin
               plan_in.f_append = 1'b1;
            end else if (even) begin
               // rebalance: back head moves to front tail
               plan_in.b_take      = 1'b1;
               plan_in.f_append    = 1'b1;
               plan_in.f_from_back = 1'b1;
               plan_in.b_append    = 1'b1;
            end else begin
               plan_in.b_append = 1'b1;
            end
         end
         mdq_pkg::OP_PUSH_MID: begin
            if (full) begin
               plan_in.status = mdq_pkg::STATUS_FULL;
            end else if (even) begin
               plan_in.f_append = 1'b1;
            end else begin
               plan_in.b_prepend = 1'b1;
            end
         end
         mdq_pkg::OP_POP: begin
            if (empty) begin
               plan_in.status = mdq_pkg::STATUS_EMPTY;
            end else begin
               plan_in.f_take = 1'b1;
               plan_in.pop_ok = 1'b1;
               if (even && back_count != '0) begin
                  plan_in.b_take      = 1'b1;
                  plan_in.f_append    = 1'b1;
                  plan_in.f_from_back = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      front_cmd.rd      = accept && plan_in.f_take;
      front_cmd.take    = exec_fire && plan_ff.f_take;
      front_cmd.append  = exec_fire && plan_ff.f_append;
      front_cmd.prepend = 1'b0;
      front_cmd.wdata   = plan_ff.f_from_back ? back_rdata : val_ff;

      back_cmd.rd       = accept && plan_in.b_take;
      back_cmd.take     = exec_fire && plan_ff.b_take;
      back_cmd.append   = exec_fire && plan_ff.b_append;
      back_cmd.prepend  = exec_fire && plan_ff.b_prepend;
      back_cmd.wdata    = val_ff;
   end

   mdq_ring u_front (
      .clock (clock),
      .reset (reset),
      .cmd   (front_cmd),
      .count (front_count),
      .rdata (front_rdata)
   );

   mdq_ring u_back (
      .clock (clock),
      .reset (reset),
      .cmd   (back_cmd),
      .count (back_count),
      .rdata (back_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready && !exec_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
                  plan_ff  <= plan_in;
                  val_ff   <= req_chan.value;
               end
            end
            ST_EXEC: begin
               // hold until the output register can take the response
               if (exec_fire) begin
                  state_ff      <= ST_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_popped_ff <= plan_ff.pop_ok ? front_rdata : '0;
                  rsp_status_ff <= plan_ff.status;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `MDQ_ASSERT(a_balance, front_count - back_count <= mdq_pkg::CNT_W'(1), "halves unbalanced")
   `MDQ_ASSERT(a_total_bound, total <= mdq_pkg::NUM_W'(mdq_pkg::CAPACITY), "over capacity")
   `MDQ_ASSERT_NEXT(a_one_in_flight, accept, !req_chan.ready, "request taken while busy")

endmodule

`default_nettype wire

/* bench/middle_insert_queue_tb.sv */
module middle_insert_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Operation code three does nothing; the package has no name for it.
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [mdq_pkg::DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [mdq_pkg::DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic signed [mdq_pkg::DATA_W-1:0] popped_value;
      logic [1:0]                        status;
   } queue_response_type;

   logic clock = 1'b0;
   logic reset;

   mdq_req_if req_chan ();
   mdq_rsp_if rsp_chan ();

   middle_insert_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #10 clock = ~clock;

   logic [mdq_pkg::DATA_W-1:0] held_values[$];
   queue_response_type         pending_responses[$];
   int                         mismatch_count = 0;
   int                         sender_idle_pct = 0;
   int                         rsp_stall_pct = 0;
   int                         rsp_hold_cycles = 0;
   int                         quiet_cycles = 0;

   // Whole queue as one ordered list: the front half is its first ceil(n/2)
   // entries, so a middle push lands at index ceil(n/2).
   function automatic queue_response_type predict_response(
      input logic [1:0] op,
      input logic [mdq_pkg::DATA_W-1:0] val);
      queue_response_type rsp;
      int                 n;
      n = held_values.size();
      rsp.popped_value = '0;
      rsp.status = mdq_pkg::STATUS_DONE;
      case (op)
         mdq_pkg::OP_PUSH_TAIL: begin
            if (n >= mdq_pkg::CAPACITY) rsp.status = mdq_pkg::STATUS_FULL;
            else held_values.push_back(val);
         end
         mdq_pkg::OP_PUSH_MID: begin
            if (n >= mdq_pkg::CAPACITY) rsp.status = mdq_pkg::STATUS_FULL;
            else held_values.insert((n + 1) / 2, val);
         end
         mdq_pkg::OP_POP: begin
            if (n == 0) rsp.status = mdq_pkg::STATUS_EMPTY;
            else rsp.popped_value = held_values.pop_front();
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   task automatic send_request(input logic [1:0] op,
                               input logic [mdq_pkg::DATA_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.value <= val;
      do @(posedge clock); while (!req_chan.ready);
      pending_responses.push_back(predict_response(op, val));
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_empty_queue();
      send_request(mdq_pkg::OP_POP, 32'h1234_5678);
      send_request(OP_NONE, 32'hFFFF_FFFF);
      send_request(mdq_pkg::OP_PUSH_TAIL, VALUE_MIN);
      send_request(mdq_pkg::OP_POP, '0);
      send_request(mdq_pkg::OP_PUSH_MID, VALUE_MAX);
      send_request(mdq_pkg::OP_POP, '0);
      send_request(mdq_pkg::OP_POP, '0);
   endtask

   task automatic test_mixed_ops();
      send_request(mdq_pkg::OP_PUSH_TAIL, VALUE_MAX);
      send_request(mdq_pkg::OP_PUSH_TAIL, VALUE_MIN);
      send_request(mdq_pkg::OP_PUSH_MID, 32'h0000_0000);
      send_request(mdq_pkg::OP_PUSH_TAIL, 32'hFFFF_FFFF);
      send_request(mdq_pkg::OP_PUSH_MID, 32'h5555_5555);
      send_request(OP_NONE, 32'h0F0F_0F0F);
      send_request(mdq_pkg::OP_PUSH_MID, 32'hAAAA_AAAA);
      send_request(mdq_pkg::OP_POP, 32'hFFFF_FFFF);
      send_request(mdq_pkg::OP_PUSH_MID, 32'h0000_0001);
      for (int i = 0; i < 7; i++) send_request(mdq_pkg::OP_POP, '0);
      send_request(mdq_pkg::OP_POP, '0);
   endtask

   // Hold the response side off long enough for the block to back up its input.
   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      for (int i = 0; i < 16; i++)
         send_request(i % 3 == 2 ? mdq_pkg::OP_POP :
                      (i[0] ? mdq_pkg::OP_PUSH_MID : mdq_pkg::OP_PUSH_TAIL), $urandom);
   endtask

   // Push a random mix of tail and middle values until the queue holds target entries.
   task automatic test_fill(input int target);
      while (held_values.size() < target)
         send_request($urandom_range(1) ? mdq_pkg::OP_PUSH_MID : mdq_pkg::OP_PUSH_TAIL,
                      $urandom);
   endtask

   task automatic test_full_queue();
      while (held_values.size() < mdq_pkg::CAPACITY)
         send_request($urandom_range(1) ? mdq_pkg::OP_PUSH_MID : mdq_pkg::OP_PUSH_TAIL,
                      $urandom);
      send_request(mdq_pkg::OP_PUSH_TAIL, $urandom);
      send_request(mdq_pkg::OP_PUSH_MID, $urandom);
      send_request(OP_NONE, $urandom);
      send_request(mdq_pkg::OP_POP, '0);
      send_request(mdq_pkg::OP_PUSH_MID, $urandom);
      send_request(mdq_pkg::OP_PUSH_TAIL, $urandom);
      for (int i = 0; i < 16; i++) send_request(mdq_pkg::OP_POP, $urandom);
   endtask

   // Response checker and ready driver.
   initial begin
      queue_response_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_responses.size() == 0) begin
               $error("unexpected response: popped_value %0d status %0d",
                      rsp_chan.popped_value, rsp_chan.status);
               mismatch_count++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_chan.popped_value !== want.popped_value) begin
                  $error("popped_value: expected %0d, got %0d",
                         want.popped_value, rsp_chan.popped_value);
                  mismatch_count++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("middle_insert_queue_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.operation <= OP_NONE;
      req_chan.value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_mixed_ops();
      test_backpressure();

      // fill the queue in stretches, one idling phase each
      set_idling(0, 0);
      test_fill(mdq_pkg::CAPACITY / 4);
      set_idling(53, 0);
      test_fill(mdq_pkg::CAPACITY / 2);
      set_idling(0, 53);
      test_fill(3 * mdq_pkg::CAPACITY / 4);
      set_idling(9, 9);
      test_full_queue();

      req_chan.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("middle_insert_queue_tb: done, clean");
      else
         $display("middle_insert_queue_tb: done, errors");
      $finish;
   end

endmodule
